[rtl/firlt_pkg.sv]
// Shared types and constants for the loadable-tap FIR filter.
// No dependencies; every other file of the block but firlt_ram imports this package.
`timescale 1ns / 1ps

package firlt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 12;
   localparam int TAPS_W   = 13;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 48;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } firlt_state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctrl_type;

   typedef struct packed {
      logic                       busy;
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } mac_stat_type;

endpackage

[rtl/firlt_channels.sv]
// Valid/ready stream interfaces for the request and response channels.
// Depends on firlt_pkg for the field widths.
`timescale 1ns / 1ps

interface firlt_req_if;
   import firlt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [INDEX_W-1:0]         coef_index;
   logic signed [SAMPLE_W-1:0] coef_value;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, kind, coef_index, coef_value, sample, input ready);
   modport sink   (input valid, kind, coef_index, coef_value, sample, output ready);
endinterface

interface firlt_rsp_if;
   import firlt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic                       clipped;

   modport source (output valid, filtered, clipped, input ready);
   modport sink   (input valid, filtered, clipped, output ready);
endinterface

[rtl/fir_filter_loadable_taps.sv]
// Top level of the loadable-tap FIR filter: sequencer, tap and delay RAMs, MAC.
// Depends on firlt_pkg, firlt_channels, firlt_ram and firlt_mac.
//
// A direct-form FIR filter for signed 16-bit samples. A request transfer of
// kind load writes one Q1.15 coefficient at coef_index and returns nothing;
// indexes at or above MAX_TAPS are dropped. A request transfer of kind sample
// pushes the sample into a circular delay line and returns one response
// transfer carrying the rounded, saturated sum of coefficient times delayed
// sample over the taps in use, with a clip flag. The taps-in-use register is
// written through csr_wr_en/csr_wr_data, only while the block is idle; the user
// must keep to this, as the block itself does not enforce it. Zero counts as
// one and values above MAX_TAPS count as MAX_TAPS. History before the first
// sample is zero: a fill count limits the walk to the samples seen since
// reset, so no clearing pass is needed. Coefficients must be loaded before any
// tap that is used reads them. A sample walks N taps, N being the smaller of
// the effective taps in use and the samples seen since reset, at one tap per
// cycle through each RAM's one read port and the shared multiplier. A result
// may wait in the response register while the next request is accepted.
`timescale 1ns / 1ps

module fir_filter_loadable_taps #(
   parameter int MAX_TAPS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   firlt_req_if.sink                     req,
   firlt_rsp_if.source                   rsp,
   input  logic                          csr_wr_en,
   input  logic [firlt_pkg::TAPS_W-1:0]  csr_wr_data
);
   import firlt_pkg::*;

   // Address width of the RAMs, width of tap counts, and a width that holds
   // both the register and a count for the comparisons in between. The load
   // index is compared at a width that also holds MAX_TAPS itself.
   localparam int AW         = $clog2(MAX_TAPS);
   localparam int CW         = $clog2(MAX_TAPS + 1);
   localparam int TW         = (CW > TAPS_W) ? CW : TAPS_W;
   localparam int IW         = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int TAPS_RESET = (4096 > MAX_TAPS) ? MAX_TAPS : 4096;

   firlt_state_type state_ff, state_in;

   logic [TAPS_W-1:0] taps_ff, taps_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     newest_ff, newest_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     m_ff, m_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              rd_vld_ff, rd_vld_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                       rsp_clipped_ff, rsp_clipped_in;

   logic [TW-1:0]       taps_wide;
   logic [CW-1:0]       taps_eff;
   logic [CW-1:0]       fill_next;
   logic [AW-1:0]       pos_next;
   logic [IW-1:0]       idx_wide;
   logic                req_xfer;
   logic                load_ok;
   logic                issue;
   logic                rsp_free;

   logic                coef_wr_en;
   logic                delay_wr_en;
   logic [SAMPLE_W-1:0] coef_rd_data;
   logic [SAMPLE_W-1:0] delay_rd_data;

   mac_ctrl_type mac_ctrl;
   mac_stat_type mac_stat;

   // Effective tap count from the register.
   always_comb begin
      taps_wide = TW'(taps_ff);
      if (taps_wide == '0) begin
         taps_eff = CW'(1);
      end else if (taps_wide > TW'(MAX_TAPS)) begin
         taps_eff = CW'(MAX_TAPS);
      end else begin
         taps_eff = taps_wide[CW-1:0];
      end
   end

   assign fill_next = (fill_ff == CW'(MAX_TAPS)) ? fill_ff : fill_ff + 1'b1;
   assign pos_next  = (newest_ff == AW'(MAX_TAPS - 1)) ? '0 : newest_ff + 1'b1;
   assign idx_wide  = IW'(req.coef_index);
   assign load_ok   = (IW'(req.coef_index) < IW'(MAX_TAPS));
   assign req_xfer  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // Sequencer: accept, walk the taps one per cycle, let the MAC pipeline
   // drain, then hand the rounded sum to the response register.
   always_comb begin
      state_in        = state_ff;
      taps_in         = taps_ff;
      fill_in         = fill_ff;
      newest_in       = newest_ff;
      n_in            = n_ff;
      m_in            = m_ff;
      slot_in         = slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_clipped_in  = rsp_clipped_ff;
      req.ready       = 1'b0;
      issue           = 1'b0;
      coef_wr_en      = 1'b0;
      delay_wr_en     = 1'b0;
      mac_ctrl.clear  = 1'b0;

      if (csr_wr_en) begin
         taps_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.kind == KIND_LOAD) begin
                  coef_wr_en = load_ok;
               end else begin
                  // The new sample is written now and read back at tap zero
                  // on a later cycle, so reads and this write never collide.
                  delay_wr_en    = 1'b1;
                  mac_ctrl.clear = 1'b1;
                  newest_in      = pos_next;
                  fill_in        = fill_next;
                  n_in           = (taps_eff < fill_next) ? taps_eff : fill_next;
                  m_in           = '0;
                  slot_in        = pos_next;
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            issue   = 1'b1;
            m_in    = m_ff + 1'b1;
            slot_in = (slot_ff == '0) ? AW'(MAX_TAPS - 1) : slot_ff - 1'b1;
            if (m_ff == n_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_stat.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = mac_stat.filtered;
               rsp_clipped_in  = mac_stat.clipped;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in     = issue;
      mac_ctrl.step = rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taps_ff      <= TAPS_W'(TAPS_RESET);
         fill_ff      <= '0;
         newest_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taps_ff      <= taps_in;
         fill_ff      <= fill_in;
         newest_ff    <= newest_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      m_ff            <= m_in;
      slot_ff         <= slot_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_clipped_ff  <= rsp_clipped_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.filtered = rsp_filtered_ff;
   assign rsp.clipped  = rsp_clipped_ff;

   // Tap table, addressed by tap number.
   firlt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data (req.coef_value),
      .rd_en   (issue),
      .rd_addr (m_ff[AW-1:0]),
      .rd_data (coef_rd_data)
   );

   // Circular delay line, walked backward from the newest slot.
   firlt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (delay_wr_en),
      .wr_addr (pos_next),
      .wr_data (req.sample),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (delay_rd_data)
   );

   firlt_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (coef_rd_data),
      .samp  (delay_rd_data),
      .stat  (mac_stat)
   );

`ifndef SYNTH
   // New requests are only taken with the MAC pipeline empty.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!rd_vld_ff && !mac_stat.busy))
      else $error("request accepted while MAC pipeline busy");

   // The tap walk stays within the count latched for this sample.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((m_ff < n_ff) && (n_ff != '0)
                                && (n_ff <= CW'(MAX_TAPS))))
      else $error("tap index outside the latched tap count");

   // The fill count saturates at the delay line depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_TAPS))
      else $error("fill count beyond delay line depth");

   // A response appears only when a sample finishes.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp.ready) && !$past(reset))
      |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");
`endif

endmodule

[rtl/firlt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module firlt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/firlt_mac.sv]
// Multiply-accumulate datapath with Q15 rounding and 16-bit saturation.
// Depends on firlt_pkg for widths and the control and status structs.
`timescale 1ns / 1ps

module firlt_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  firlt_pkg::mac_ctrl_type              ctrl,
   input  logic signed [firlt_pkg::SAMPLE_W-1:0] coef,
   input  logic signed [firlt_pkg::SAMPLE_W-1:0] samp,
   output firlt_pkg::mac_stat_type              stat
);
   import firlt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     mul_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  biased;
   logic signed [ACC_W-16:0] rounded;

   always_comb begin
      prod_in = coef * samp;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= ctrl.step;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Add half an LSB of the Q15 result, then drop fifteen fraction bits.
   always_comb begin
      biased    = acc_ff + 48'sd16384;
      rounded   = biased[ACC_W-1:15];
      stat.busy = mul_vld_ff;
      if (rounded > 33'sd32767) begin
         stat.filtered = 16'sh7FFF;
         stat.clipped  = 1'b1;
      end else if (rounded < -33'sd32768) begin
         stat.filtered = 16'sh8000;
         stat.clipped  = 1'b1;
      end else begin
         stat.filtered = rounded[SAMPLE_W-1:0];
         stat.clipped  = 1'b0;
      end
   end

endmodule

[tb/fir_filter_loadable_taps_tb.sv]
// Self-checking testbench for the loadable-tap FIR filter, top module last.
// Depends on firlt_pkg, firlt_channels and the fir_filter_loadable_taps RTL.
`timescale 1ns / 1ps

module fir_filter_loadable_taps_tb;
   import firlt_pkg::*;

   localparam int FIR_TAPS       = 4096;
   localparam int LOADED_TAPS    = 32;
   localparam int MAX_GAP        = 13;
   localparam int MAX_REPORTS    = 10;
   localparam int CSR_SETTLE     = 8;
   localparam int END_SETTLE     = 20;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 60;

   localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } fir_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_wr_en;
   logic [TAPS_W-1:0] csr_wr_data;

   firlt_req_if req_ch ();
   firlt_rsp_if rsp_ch ();

   fir_filter_loadable_taps #(
      .MAX_TAPS    (FIR_TAPS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the filter: coefficient table, circular sample history,
   // the slot of the newest sample and the taps-in-use register.
   logic signed [SAMPLE_W-1:0] tap_coef [FIR_TAPS];
   logic signed [SAMPLE_W-1:0] history  [FIR_TAPS];
   logic [INDEX_W-1:0]         newest_slot;
   logic [TAPS_W-1:0]          taps_reg;

   fir_result_type expected_outputs [$];
   int error_count     = 0;
   int idle_cycles     = 0;
   int rsp_hold_cycles = 0;
   int random_items    = 0;
   bit no_gaps         = 1'b0;

   // The register value as the filter uses it: zero counts as one and
   // anything past the table size counts as the full table.
   function automatic int active_tap_count();
      int count;
      count = taps_reg;
      if (count == 0) count = 1;
      if (count > FIR_TAPS) count = FIR_TAPS;
      return count;
   endfunction

   // Shifts one sample into the history and forms the rounded, saturated
   // output. Halves round toward plus infinity through the add-then-shift.
   function automatic fir_result_type filter_sample(input logic signed [SAMPLE_W-1:0] pcm);
      longint             acc;
      longint             rounded;
      int                 count;
      logic [INDEX_W-1:0] slot;
      fir_result_type     res;
      newest_slot = newest_slot + 1'b1;
      history[newest_slot] = pcm;
      count = active_tap_count();
      acc = 0;
      for (int m = 0; m < count; m++) begin
         slot = newest_slot - INDEX_W'(m);
         acc += longint'(tap_coef[m]) * longint'(history[slot]);
      end
      rounded = (acc + 64'sd16384) >>> 15;
      if (rounded > longint'(PCM_MAX)) begin
         res.filtered = PCM_MAX;
         res.clipped  = 1'b1;
      end else if (rounded < longint'(PCM_MIN)) begin
         res.filtered = PCM_MIN;
         res.clipped  = 1'b1;
      end else begin
         res.filtered = rounded[SAMPLE_W-1:0];
         res.clipped  = 1'b0;
      end
      return res;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return PCM_MIN;
         1: return PCM_MAX;
         2: return $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] small_coef();
      return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
   endfunction

   task automatic note_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
   endtask

   // Offers one request and returns at the edge where the transfer happens.
   // The decision is taken at the falling edge, where every signal is stable.
   task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] coef,
                            input logic signed [SAMPLE_W-1:0] pcm);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.coef_index <= idx;
      req_ch.coef_value <= coef;
      req_ch.sample     <= pcm;
      do @(negedge clock); while (req_ch.ready !== 1'b1);
      if (kind == KIND_LOAD) tap_coef[idx] = coef;
      else expected_outputs.push_back(filter_sample(pcm));
      @(posedge clock);
   endtask

   task automatic load_coef(input int idx, input logic signed [SAMPLE_W-1:0] coef);
      send_item(KIND_LOAD, INDEX_W'(idx), coef, SAMPLE_W'($urandom));
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] pcm);
      send_item(KIND_SAMPLE, INDEX_W'($urandom), SAMPLE_W'($urandom), pcm);
   endtask

   // The sender stops offering and waits until every result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with the filter idle. A trailing load gives
   // no result, so a settling wait comes before the write.
   task automatic write_taps(input int value);
      wait_drained();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= TAPS_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      taps_reg     = TAPS_W'(value);
   endtask

   // Narrows the walk to the taps that get loaded here, before any sample,
   // so no tap is ever read unwritten, then filters a few samples.
   task automatic test_coef_load();
      write_taps(LOADED_TAPS);
      for (int i = 0; i < LOADED_TAPS; i++) begin
         load_coef(i, (i < 8) ? SAMPLE_W'($urandom) : small_coef());
      end
      push_sample(PCM_MAX);
      push_sample(PCM_MIN);
      push_sample(pick_sample());
      push_sample(pick_sample());
   endtask

   // Single- and two-tap cases around the rounding point and both clip rails.
   task automatic test_rounding_and_clipping();
      write_taps(1);
      load_coef(0, PCM_MIN);
      push_sample(PCM_MIN);
      push_sample(PCM_MAX);
      load_coef(0, 16'sd16384);
      push_sample(16'sd1);
      push_sample(-16'sd1);
      load_coef(0, PCM_MAX);
      push_sample(PCM_MAX);
      write_taps(2);
      load_coef(0, PCM_MIN);
      load_coef(1, PCM_MIN);
      push_sample(PCM_MAX);
      push_sample(PCM_MIN);
   endtask

   // Zero taps behaves as one.
   task automatic test_tap_count_limits();
      write_taps(0);
      push_sample(pick_sample());
      push_sample(pick_sample());
   endtask

   // The receiver stalls for a long stretch while requests keep coming, so
   // the held result backs up into the request channel.
   task automatic test_output_backpressure();
      write_taps(5);
      rsp_hold_cycles = 400;
      repeat (20) push_sample(pick_sample());
   endtask

   // Phases with a random tap count within the loaded taps; mostly samples
   // with loads mixed in, most loads landing on taps that are in use.
   task automatic test_random_traffic();
      int taps;
      int burst;
      int idx;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       taps = 0;
            1:       taps = LOADED_TAPS;
            default: taps = $urandom_range(1, LOADED_TAPS);
         endcase
         write_taps(taps);
         burst = int'($urandom_range(10, 25));
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (burst) begin
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, FIR_TAPS - 1);
               else idx = $urandom_range(0, active_tap_count() - 1);
               load_coef(idx, $urandom_range(0, 1) ? SAMPLE_W'($urandom) : small_coef());
            end else begin
               push_sample(pick_sample());
            end
            random_items++;
         end
         no_gaps = 1'b0;
      end
   endtask

   // Result side: draws a stall before each transfer, or takes the long hold
   // when one is requested, and checks each transfer at the falling edge.
   initial begin : result_checker
      int             pause;
      fir_result_type want;
      forever begin
         if (rsp_hold_cycles > 0) begin
            pause = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            pause = draw_gap();
         end
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (rsp_ch.valid !== 1'b1);
         if (expected_outputs.size() == 0) begin
            note_error($sformatf("response with no sample pending: filtered %0d clipped %0b",
                                 rsp_ch.filtered, rsp_ch.clipped));
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_ch.filtered !== want.filtered)
               note_error($sformatf("filtered: expected %0d, got %0d",
                                    want.filtered, rsp_ch.filtered));
            if (rsp_ch.clipped !== want.clipped)
               note_error($sformatf("clipped: expected %0b, got %0b",
                                    want.clipped, rsp_ch.clipped));
         end
         @(posedge clock);
      end
   end

   // Any cycle without a transfer or register write counts toward the limit.
   always @(negedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || csr_wr_en === 1'b1) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      foreach (history[i]) history[i] = '0;
      foreach (tap_coef[i]) tap_coef[i] = '0;
      newest_slot = '0;
      taps_reg    = TAPS_W'(FIR_TAPS);
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_LOAD;
      req_ch.coef_index <= '0;
      req_ch.coef_value <= '0;
      req_ch.sample     <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_coef_load();
      test_rounding_and_clipping();
      test_tap_count_limits();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[fir_filter_loadable_taps.f]
rtl/firlt_pkg.sv
rtl/firlt_channels.sv
rtl/firlt_ram.sv
rtl/firlt_mac.sv
rtl/fir_filter_loadable_taps.sv
tb/fir_filter_loadable_taps_tb.sv
